/* rtl/positional_list_engine_defines.svh */
// ---------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// implication checked on every edge outside reset
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must hold on every edge outside reset
`define PLE_ASSERT_ALWAYS(label, cond, msg) \
  `PLE_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

/* rtl/ple_pkg.sv */
// ---------------------------------------------------------------------------
// ple_pkg
// widths, codes and cell command type for the positional list engine
// ---------------------------------------------------------------------------
package ple_pkg;

  // list depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 5;

  // request kinds
  typedef enum logic [2:0] {
    KIND_APPEND   = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_POS  = 3'd2,
    KIND_DEL_HEAD = 3'd3,
    KIND_DEL_POS  = 3'd4,
    KIND_ROTATE   = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // per-cycle operation broadcast along the cell row
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_ROT   = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [CNT_W-1:0]   at;
    logic [VAL_W-1:0]   value;
  } cell_cmd_t;

endpackage

/* rtl/ple_cell.sv */
// ---------------------------------------------------------------------------
// ple_cell
// one list slot: holds a value and shifts with its neighbours on command
// ---------------------------------------------------------------------------
module ple_cell (
  input  logic                             clk_i,
  input  logic [ple_pkg::IDX_W-1:0]        idx_i,
  input  ple_pkg::cell_cmd_t               cmd_i,
  input  logic [ple_pkg::VAL_W-1:0]        left_i,
  input  logic [ple_pkg::VAL_W-1:0]        right_i,
  input  logic [ple_pkg::VAL_W-1:0]        head_i,
  input  logic [ple_pkg::CNT_W-1:0]        tail_at_i,
  output logic [ple_pkg::VAL_W-1:0]        value_o,
  output logic [ple_pkg::VAL_W-1:0]        tail_o
);

  logic [ple_pkg::VAL_W-1:0] value_q, value_d;
  logic [ple_pkg::CNT_W-1:0] idx_ext;

  assign idx_ext = ple_pkg::CNT_W'(idx_i);

  // slot update from own position relative to the gap
  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      ple_pkg::OP_OPEN: begin
        if (idx_ext > cmd_i.at) begin
          value_d = left_i;
        end else if (idx_ext == cmd_i.at) begin
          value_d = cmd_i.value;
        end
      end
      ple_pkg::OP_CLOSE: begin
        if (idx_ext >= cmd_i.at) begin
          value_d = right_i;
        end
      end
      ple_pkg::OP_ROT: begin
        if (idx_ext < cmd_i.at) begin
          value_d = right_i;
        end else if (idx_ext == cmd_i.at) begin
          value_d = head_i;
        end
      end
      ple_pkg::OP_HOLD: begin
        value_d = value_q;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // contributes to the tail or-tree only when this slot is last
  assign tail_o  = (idx_ext == tail_at_i) ? value_q : '0;

endmodule

/* rtl/ple_ctrl.sv */
// ---------------------------------------------------------------------------
// ple_ctrl
// request decode: checks, status and the command broadcast to the cells
// ---------------------------------------------------------------------------
module ple_ctrl (
  input  logic                             take_i,
  input  logic [2:0]                       kind_i,
  input  logic [ple_pkg::POS_W-1:0]        position_i,
  input  logic [ple_pkg::VAL_W-1:0]        item_value_i,
  input  logic [ple_pkg::CNT_W-1:0]        count_i,
  output ple_pkg::cell_cmd_t               cmd_o,
  output ple_pkg::status_e                 status_o,
  output logic [ple_pkg::CNT_W-1:0]        count_d_o
);

  logic                      full, empty;
  logic [ple_pkg::CMP_W-1:0] pos_ext, cnt_ext;
  ple_pkg::kind_e            kind;

  assign full    = (count_i == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty   = (count_i == '0);
  assign pos_ext = ple_pkg::CMP_W'(position_i);
  assign cnt_ext = ple_pkg::CMP_W'(count_i);
  assign kind    = ple_pkg::kind_e'(kind_i);

  // decode of one transaction
  always_comb begin
    cmd_o.op    = ple_pkg::OP_HOLD;
    cmd_o.at    = '0;
    cmd_o.value = item_value_i;
    status_o    = ple_pkg::ST_OK;
    count_d_o   = count_i;
    if (take_i) begin
      unique case (kind)
        ple_pkg::KIND_APPEND: begin
          if (full) begin
            status_o = ple_pkg::ST_FULL;
          end else begin
            cmd_o.op  = ple_pkg::OP_OPEN;
            cmd_o.at  = count_i;
            count_d_o = count_i + 1'b1;
          end
        end
        ple_pkg::KIND_INS_HEAD: begin
          if (full) begin
            status_o = ple_pkg::ST_FULL;
          end else begin
            cmd_o.op  = ple_pkg::OP_OPEN;
            count_d_o = count_i + 1'b1;
          end
        end
        ple_pkg::KIND_INS_POS: begin
          priority if (empty) begin
            status_o = ple_pkg::ST_EMPTY;
          end else if (pos_ext > cnt_ext) begin
            status_o = ple_pkg::ST_BADPOS;
          end else if (full) begin
            status_o = ple_pkg::ST_FULL;
          end else begin
            cmd_o.op  = ple_pkg::OP_OPEN;
            cmd_o.at  = ple_pkg::CNT_W'(pos_ext);
            count_d_o = count_i + 1'b1;
          end
        end
        ple_pkg::KIND_DEL_HEAD: begin
          if (empty) begin
            status_o = ple_pkg::ST_EMPTY;
          end else begin
            cmd_o.op  = ple_pkg::OP_CLOSE;
            count_d_o = count_i - 1'b1;
          end
        end
        ple_pkg::KIND_DEL_POS: begin
          priority if (empty) begin
            status_o = ple_pkg::ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            status_o = ple_pkg::ST_BADPOS;
          end else begin
            cmd_o.op  = ple_pkg::OP_CLOSE;
            cmd_o.at  = ple_pkg::CNT_W'(pos_ext);
            count_d_o = count_i - 1'b1;
          end
        end
        ple_pkg::KIND_ROTATE: begin
          if (empty) begin
            status_o = ple_pkg::ST_EMPTY;
          end else begin
            cmd_o.op = ple_pkg::OP_ROT;
            cmd_o.at = count_i - 1'b1;
          end
        end
        default: begin
          // unused kinds report the list unchanged
          status_o = ple_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

/* rtl/positional_list_engine.sv */
// ---------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list with insert, delete and rotate over a row of cells
// ---------------------------------------------------------------------------
// Usage: drive kind_i, position_i and item_value_i with start high; the
// transaction is taken on a rising edge where start is high and busy low.
// busy never rises, so a new request may be issued on every cycle.
// The edge that takes a request updates every cell at once (each cell
// compares its index with the gap position and takes its own value, a
// neighbour's value, the new item or the head value), and in the following
// cycle done_o pulses for exactly one cycle with status_o, length_now_o,
// head_value_o and tail_value_o taken from the updated list.
// Throughput: one transaction per cycle, set by the whole-row cell
// update and the count register that feeds the next decode.
// The receiver cannot hold results off; each result is valid only while
// done_o is high.
// Reset clears the entry count and the result strobe; cell contents are
// left as they are and are never shown before being written.
// ---------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module positional_list_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  kind_i,
  input  logic [7:0]                  position_i,
  input  logic signed [31:0]          item_value_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [4:0]                  length_now_o,
  output logic signed [31:0]          head_value_o,
  output logic signed [31:0]          tail_value_o
);

  localparam int N = ple_pkg::CAPACITY;

  logic                              take;
  ple_pkg::cell_cmd_t                cmd;
  ple_pkg::status_e                  status_d, status_q;
  logic [ple_pkg::CNT_W-1:0]         count_d, count_q, tail_at;
  logic                              done_q;
  logic [ple_pkg::VAL_W-1:0]         cell_val [N];
  logic [ple_pkg::VAL_W-1:0]         cell_tail [N];
  logic [ple_pkg::VAL_W-1:0]         tail_any;

  // requests are always taken
  assign busy = 1'b0;
  assign take = start && !busy;

  // request decode
  ple_ctrl u_ctrl (
    .take_i       (take),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .count_i      (count_q),
    .cmd_o        (cmd),
    .status_o     (status_d),
    .count_d_o    (count_d)
  );

  // count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign tail_at = count_q - 1'b1;

  // row of cells, neighbours linked left and right
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ple_pkg::VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[0];
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ple_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (ple_pkg::IDX_W'(i)),
      .cmd_i     (cmd),
      .left_i    (left_v),
      .right_i   (right_v),
      .head_i    (cell_val[0]),
      .tail_at_i (tail_at),
      .value_o   (cell_val[i]),
      .tail_o    (cell_tail[i])
    );
  end

  // or-tree of the one selected tail contribution
  always_comb begin
    tail_any = '0;
    for (int k = 0; k < N; k++) begin
      tail_any = tail_any | cell_tail[k];
    end
  end

  // result ports
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign length_now_o = ple_pkg::LEN_W'(count_q);
  assign head_value_o = (count_q == '0) ? '0 : cell_val[0];
  assign tail_value_o = (count_q == '0) ? '0 : tail_any;

  // checks
  `PLE_ASSERT_ALWAYS(a_count_bound, count_q <= ple_pkg::CNT_W'(ple_pkg::CAPACITY),
                     "entry count above capacity")
  `PLE_ASSERT(a_done_follows, take |=> done_o, "accepted request gave no result")
  `PLE_ASSERT(a_done_cause, done_o |-> $past(take), "result without a request")
  `PLE_ASSERT(a_empty_len, done_o && status_q == ple_pkg::ST_EMPTY |-> count_q == '0,
              "empty status with entries present")
  `PLE_ASSERT(a_fail_hold,
              done_o && status_q != ple_pkg::ST_OK |-> count_q == $past(count_q),
              "rejected request changed the length")

endmodule

/* tb/positional_list_engine_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_list_engine_tb
// self-checking bench for the bounded ordered list: a queue-fed driver issues
// list requests with random idle bursts, a shadow list predicts status,
// length, head and tail for each accepted transaction, and a monitor checks
// every done strobe against the oldest prediction
// ---------------------------------------------------------------------------
module positional_list_engine_tb;

  // unused request codes, treated as no-ops by the block
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int QUIET_TAIL    = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [2:0]                       kind;
    logic [ple_pkg::POS_W-1:0]        position;
    logic signed [ple_pkg::VAL_W-1:0] value;
    int unsigned                      idle_before;
  } list_request_t;

  typedef struct {
    ple_pkg::status_e                 status;
    logic [ple_pkg::LEN_W-1:0]        length;
    logic signed [ple_pkg::VAL_W-1:0] head;
    logic signed [ple_pkg::VAL_W-1:0] tail;
  } list_view_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             start        = 1'b0;
  logic                             busy;
  logic [2:0]                       kind_i       = '0;
  logic [ple_pkg::POS_W-1:0]        position_i   = '0;
  logic signed [ple_pkg::VAL_W-1:0] item_value_i = '0;
  logic                             done_o;
  logic [1:0]                       status_o;
  logic [ple_pkg::LEN_W-1:0]        length_now_o;
  logic signed [ple_pkg::VAL_W-1:0] head_value_o;
  logic signed [ple_pkg::VAL_W-1:0] tail_value_o;

  list_request_t pending_requests[$];
  list_view_t    expected_views[$];
  list_request_t next_request;
  list_view_t    oldest_view;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;

  // shadow copy of the list
  logic signed [ple_pkg::VAL_W-1:0] shadow_cells [ple_pkg::CAPACITY];
  int                               shadow_len = 0;

  positional_list_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .length_now_o (length_now_o),
    .head_value_o (head_value_o),
    .tail_value_o (tail_value_o)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shift cells up from the gap and store the new value
  function automatic void open_shadow_gap(int at, logic signed [ple_pkg::VAL_W-1:0] value);
    for (int i = shadow_len; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[at] = value;
    shadow_len++;
  endfunction

  // shift cells down over the removed entry
  function automatic void close_shadow_gap(int at);
    for (int i = at; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
    shadow_len--;
  endfunction

  // apply one request to the shadow list and return what the block should show
  function automatic list_view_t apply_list_request(
      logic [2:0] kind,
      logic [ple_pkg::POS_W-1:0] pos,
      logic signed [ple_pkg::VAL_W-1:0] value);
    list_view_t                       view;
    logic signed [ple_pkg::VAL_W-1:0] first;
    view.status = ple_pkg::ST_OK;
    case (kind)
      ple_pkg::KIND_APPEND: begin
        if (shadow_len >= ple_pkg::CAPACITY) view.status = ple_pkg::ST_FULL;
        else open_shadow_gap(shadow_len, value);
      end
      ple_pkg::KIND_INS_HEAD: begin
        if (shadow_len >= ple_pkg::CAPACITY) view.status = ple_pkg::ST_FULL;
        else open_shadow_gap(0, value);
      end
      ple_pkg::KIND_INS_POS: begin
        if (shadow_len == 0) view.status = ple_pkg::ST_EMPTY;
        else if (int'(pos) > shadow_len) view.status = ple_pkg::ST_BADPOS;
        else if (shadow_len >= ple_pkg::CAPACITY) view.status = ple_pkg::ST_FULL;
        else open_shadow_gap(int'(pos), value);
      end
      ple_pkg::KIND_DEL_HEAD: begin
        if (shadow_len == 0) view.status = ple_pkg::ST_EMPTY;
        else close_shadow_gap(0);
      end
      ple_pkg::KIND_DEL_POS: begin
        if (shadow_len == 0) view.status = ple_pkg::ST_EMPTY;
        else if (int'(pos) >= shadow_len) view.status = ple_pkg::ST_BADPOS;
        else close_shadow_gap(int'(pos));
      end
      ple_pkg::KIND_ROTATE: begin
        if (shadow_len == 0) view.status = ple_pkg::ST_EMPTY;
        else begin
          first = shadow_cells[0];
          close_shadow_gap(0);
          shadow_cells[shadow_len] = first;
          shadow_len++;
        end
      end
      default: ;
    endcase
    view.length = shadow_len[ple_pkg::LEN_W-1:0];
    view.head   = (shadow_len == 0) ? '0 : shadow_cells[0];
    view.tail   = (shadow_len == 0) ? '0 : shadow_cells[shadow_len-1];
    return view;
  endfunction

  function automatic int unsigned random_idle();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
  endfunction

  task automatic queue_request(logic [2:0] kind, logic [ple_pkg::POS_W-1:0] pos,
                               logic signed [ple_pkg::VAL_W-1:0] value, int unsigned idle);
    list_request_t req;
    req.kind        = kind;
    req.position    = pos;
    req.value       = value;
    req.idle_before = idle;
    pending_requests.push_back(req);
  endtask

  // driver: record accepted transactions, then present the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      kind_i       <= '0;
      position_i   <= '0;
      item_value_i <= '0;
    end else begin
      if (start && !busy)
        expected_views.push_back(apply_list_request(kind_i, position_i, item_value_i));
      if (!start || !busy) begin
        if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else if (pending_requests[0].idle_before != 0) begin
          pending_requests[0].idle_before--;
          start <= 1'b0;
        end else begin
          next_request  = pending_requests.pop_front();
          start        <= 1'b1;
          kind_i       <= next_request.kind;
          position_i   <= next_request.position;
          item_value_i <= next_request.value;
        end
      end
    end
  end

  // monitor: each done strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: status %0d length %0d head %0d tail %0d",
                   status_o, length_now_o, head_value_o, tail_value_o);
      end else begin
        oldest_view = expected_views.pop_front();
        if (status_o !== oldest_view.status || length_now_o !== oldest_view.length ||
            head_value_o !== oldest_view.head || tail_value_o !== oldest_view.tail) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result mismatch: exp st %0d len %0d head %0d tail %0d",
                     oldest_view.status, oldest_view.length, oldest_view.head,
                     oldest_view.tail);
            $display("                 got st %0d len %0d head %0d tail %0d",
                     status_o, length_now_o, head_value_o, tail_value_o);
          end
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    bit                               growing;
    int                               segment_left;
    int unsigned                      roll;
    logic [2:0]                       kind;
    logic [ple_pkg::POS_W-1:0]        pos;
    logic signed [ple_pkg::VAL_W-1:0] value;

    // empty list: removals, rotate and positional insert all report empty
    queue_request(ple_pkg::KIND_DEL_HEAD, 8'd0, 32'sd0, 0);
    queue_request(ple_pkg::KIND_DEL_POS, 8'd0, 32'sd0, random_idle());
    queue_request(ple_pkg::KIND_ROTATE, 8'd0, 32'sd0, 0);
    queue_request(ple_pkg::KIND_INS_POS, 8'd0, VAL_MAX, random_idle());
    // insert head on an empty list inserts
    queue_request(ple_pkg::KIND_INS_HEAD, 8'hff, VAL_MIN, 0);
    // single entry rotate leaves it alone
    queue_request(ple_pkg::KIND_ROTATE, 8'd0, 32'sd0, 0);
    // delete at position equal to length, and far out of range
    queue_request(ple_pkg::KIND_DEL_POS, 8'd1, 32'sd0, random_idle());
    queue_request(ple_pkg::KIND_DEL_POS, 8'hff, 32'sd0, 0);
    // positional insert at the length appends, beyond it is invalid
    queue_request(ple_pkg::KIND_INS_POS, 8'd1, VAL_MAX, 0);
    queue_request(ple_pkg::KIND_INS_POS, 8'd3, -32'sd1, random_idle());
    queue_request(KIND_SPARE_6, 8'haa, 32'sh5555_5555, 0);
    queue_request(KIND_SPARE_7, 8'h55, 32'shaaaa_aaaa, 0);
    // fill to capacity with mixed inserts
    for (int i = 0; i < ple_pkg::CAPACITY - 2; i++)
      queue_request((i % 3 == 0) ? ple_pkg::KIND_INS_POS : ple_pkg::KIND_APPEND, 8'(i / 2),
                    (i % 2 == 0) ? -32'sd1 : 32'(i), random_idle());
    // full list rejects every insert, a bad position still wins over full
    queue_request(ple_pkg::KIND_APPEND, 8'd0, 32'sd7, 0);
    queue_request(ple_pkg::KIND_INS_HEAD, 8'd0, 32'sd7, 0);
    queue_request(ple_pkg::KIND_INS_POS, 8'd4, 32'sd7, 0);
    queue_request(ple_pkg::KIND_INS_POS, 8'hff, 32'sd7, random_idle());
    queue_request(ple_pkg::KIND_ROTATE, 8'd0, 32'sd0, 0);
    queue_request(ple_pkg::KIND_DEL_POS, 8'(ple_pkg::CAPACITY - 1), 32'sd0, 0);
    queue_request(ple_pkg::KIND_DEL_HEAD, 8'd0, 32'sd0, 0);

    // random part: alternating grow and shrink stretches sweep empty to full
    growing      = 1'b0;
    segment_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (segment_left == 0) begin
        growing      = !growing;
        segment_left = $urandom_range(8, 40);
      end
      segment_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        kind = 3'($urandom_range(KIND_SPARE_6, KIND_SPARE_7));
      else if ((roll < 72) == growing)
        kind = 3'($urandom_range(ple_pkg::KIND_APPEND, ple_pkg::KIND_INS_POS));
      else
        kind = 3'($urandom_range(ple_pkg::KIND_DEL_HEAD, ple_pkg::KIND_ROTATE));
      pos = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ple_pkg::CAPACITY + 1))
                                         : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
        0:       value = VAL_MIN;
        1:       value = VAL_MAX;
        2:       value = '0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase
      queue_request(kind, pos, value, (n >= RANDOM_ITEMS - QUIET_TAIL) ? 0 : random_idle());
    end

    // single reset at the start
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests taken and all results seen
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || start || expected_views.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_views.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", expected_views.size());
    end
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
tb/positional_list_engine_tb.sv
